// File: design/knob_smoother_with_stepped_map_macros.svh
`ifndef KNOB_SMOOTHER_WITH_STEPPED_MAP_MACROS_SVH
`define KNOB_SMOOTHER_WITH_STEPPED_MAP_MACROS_SVH

// same-cycle implication
`define KSM_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ksm assertion failed");

// next-cycle implication
`define KSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ksm assertion failed");

`endif

// File: design/ksm_pkg.sv
package ksm_pkg;

  localparam int DATA_W = 10;
  localparam int CH_W = 4;
  localparam int CH_VALUES = 16;
  localparam int CHANNEL_COUNT_DEF = 16;
  localparam int SMOOTH_SHIFT = 2;
  localparam int FULL_SCALE = 1023;

  localparam int FS_W = $clog2(FULL_SCALE + 1);
  localparam int DV_W = (FS_W > DATA_W) ? FS_W : DATA_W;
  localparam int DVD_W = DATA_W + DV_W;

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 32;
  localparam int M_USED_W = CH_W + DATA_W + 1 + 2 + DATA_W + 1;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_HYSTERESIS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_A_CHANNEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_A_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_A_MAX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_B_CHANNEL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_B_MIN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_B_MAX = 3'd7;

  localparam logic [DATA_W-1:0] RST_CHANGE_THRESHOLD = 10'd3;
  localparam logic [DATA_W-1:0] RST_STEP_HYSTERESIS = 10'd8;
  localparam logic [CH_W-1:0] RST_STEP_A_CHANNEL = 4'd9;
  localparam logic [DATA_W-1:0] RST_STEP_A_MIN = 10'd40;
  localparam logic [DATA_W-1:0] RST_STEP_A_MAX = 10'd240;
  localparam logic [CH_W-1:0] RST_STEP_B_CHANNEL = 4'd10;
  localparam logic [DATA_W-1:0] RST_STEP_B_MIN = 10'd1;
  localparam logic [DATA_W-1:0] RST_STEP_B_MAX = 10'd64;

  localparam logic [1:0] HIT_NONE = 2'd0;
  localparam logic [1:0] HIT_A = 2'd1;
  localparam logic [1:0] HIT_B = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_SMOOTH,
    ST_MUL,
    ST_GO,
    ST_WAIT,
    ST_CAND,
    ST_CMUL,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic cap_in;
    logic rd;
    logic smooth;
    logic mul;
    logic cmul;
    logic div_start;
    logic cand;
    logic fin;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic stepped;
    logic need_centre;
    logic div_busy;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// File: design/ksm_div.sv
module ksm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ksm_pkg::DVD_W-1:0]  dividend,
  input  logic [ksm_pkg::DV_W-1:0]   divisor,
  output logic [ksm_pkg::DVD_W-1:0]  quotient,
  output logic                       busy,
  output logic                       done
);

  localparam int CNT_W = $clog2(ksm_pkg::DVD_W + 1);

  logic [ksm_pkg::DV_W-1:0]  rem;
  logic [ksm_pkg::DV_W-1:0]  dvs;
  logic [CNT_W-1:0]          cnt;
  logic [ksm_pkg::DV_W:0]    shifted;
  logic                      qbit;
  logic [ksm_pkg::DV_W-1:0]  rem_next;

  always_comb begin
    shifted = {rem, quotient[ksm_pkg::DVD_W-1]};
    qbit = (shifted >= {1'b0, dvs});
    if (qbit) begin
      rem_next = ksm_pkg::DV_W'(shifted - {1'b0, dvs});
    end else begin
      rem_next = shifted[ksm_pkg::DV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(ksm_pkg::DVD_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quotient <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quotient <= {quotient[ksm_pkg::DVD_W-2:0], qbit};
    end
  end

endmodule

// File: design/ksm_datapath.sv
module ksm_datapath #(
  parameter int CHANNEL_COUNT = ksm_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ksm_pkg::cmd_t                   cmd,
  output ksm_pkg::stat_t                  stat,
  input  logic [ksm_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic                            cfg_we,
  input  logic [ksm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ksm_pkg::DATA_W-1:0]      cfg_data,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ksm_pkg::M_TDATA_W-1:0]   m_tdata
);

  localparam int DW = ksm_pkg::DATA_W;
  localparam int IDX_W = $clog2(CHANNEL_COUNT);
  localparam int SW = DW + ksm_pkg::SMOOTH_SHIFT + 1;
  localparam int CW = ksm_pkg::DVD_W + 2;

  logic [DW-1:0]           thr, hyst, a_min, a_max, b_min, b_max;
  logic [ksm_pkg::CH_W-1:0] a_ch, b_ch;

  logic [IDX_W-1:0]        idx_tab [ksm_pkg::CH_VALUES];
  logic [ksm_pkg::CH_W-1:0] ch_r;
  logic [DW-1:0]           smp_r;
  logic [IDX_W-1:0]        idx_r;

  logic [DW-1:0]           smem [CHANNEL_COUNT];
  logic [DW-1:0]           rmem [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] s_val, r_val;
  logic [DW-1:0]           s_rd, r_rd;

  logic [DW-1:0]           lvl_r, lo_r, hi_r, span_r, held_r, cand_r, sval_r;
  logic                    rep_r, degen_r, heldv_r, schg_r, sign_r;
  logic [1:0]              hit_r;
  logic [DW-1:0]           held_a, held_b;
  logic                    held_a_v, held_b_v;
  logic [ksm_pkg::DVD_W-1:0] prod_r;

  logic [SW-1:0]           acc;
  logic [DW-1:0]           lvl_c, dr_c, lo_c, hi_c, held_c;
  logic                    rep_c, heldv_c, degen_c;
  logic [1:0]              hit_c;

  logic [ksm_pkg::DV_W-1:0]  divisor;
  logic [ksm_pkg::DVD_W-1:0] quo;
  logic                      div_busy, div_done;

  logic [ksm_pkg::DVD_W:0] rq_sum;
  logic [DW-1:0]           rq;
  logic [DW:0]             cand_full;
  logic [DW-1:0]           cand_c;

  logic [DW:0]             held_diff;
  logic [DW-1:0]           held_mag;

  logic signed [CW-1:0]    centre_s, diff_s;
  logic [CW-1:0]           dabs;
  logic [DW-1:0]           ns_c;
  logic                    schg_c;

  for (genvar k = 0; k < ksm_pkg::CH_VALUES; k++) begin : g_idx
    assign idx_tab[k] = IDX_W'(k % CHANNEL_COUNT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= ksm_pkg::RST_CHANGE_THRESHOLD;
      hyst <= ksm_pkg::RST_STEP_HYSTERESIS;
      a_ch <= ksm_pkg::RST_STEP_A_CHANNEL;
      a_min <= ksm_pkg::RST_STEP_A_MIN;
      a_max <= ksm_pkg::RST_STEP_A_MAX;
      b_ch <= ksm_pkg::RST_STEP_B_CHANNEL;
      b_min <= ksm_pkg::RST_STEP_B_MIN;
      b_max <= ksm_pkg::RST_STEP_B_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        ksm_pkg::CFG_CHANGE_THRESHOLD: thr <= cfg_data;
        ksm_pkg::CFG_STEP_HYSTERESIS:  hyst <= cfg_data;
        ksm_pkg::CFG_STEP_A_CHANNEL:   a_ch <= cfg_data[ksm_pkg::CH_W-1:0];
        ksm_pkg::CFG_STEP_A_MIN:       a_min <= cfg_data;
        ksm_pkg::CFG_STEP_A_MAX:       a_max <= cfg_data;
        ksm_pkg::CFG_STEP_B_CHANNEL:   b_ch <= cfg_data[ksm_pkg::CH_W-1:0];
        ksm_pkg::CFG_STEP_B_MIN:       b_min <= cfg_data;
        ksm_pkg::CFG_STEP_B_MAX:       b_max <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    acc = SW'({s_rd, {ksm_pkg::SMOOTH_SHIFT{1'b0}}}) - SW'(s_rd) + SW'(smp_r);
    lvl_c = s_val[idx_r] ? acc[ksm_pkg::SMOOTH_SHIFT +: DW] : smp_r;
    dr_c = (lvl_c >= r_rd) ? (lvl_c - r_rd) : (r_rd - lvl_c);
    rep_c = !r_val[idx_r] || (dr_c >= thr);
    hit_c = ksm_pkg::HIT_NONE;
    if (rep_c) begin
      if (ch_r == a_ch) begin
        hit_c = ksm_pkg::HIT_A;
      end else if (ch_r == b_ch) begin
        hit_c = ksm_pkg::HIT_B;
      end
    end
    if (hit_c == ksm_pkg::HIT_B) begin
      lo_c = b_min;
      hi_c = b_max;
      held_c = held_b;
      heldv_c = held_b_v;
    end else begin
      lo_c = a_min;
      hi_c = a_max;
      held_c = held_a;
      heldv_c = held_a_v;
    end
    degen_c = (hi_c <= lo_c);
  end

  // divide by FULL_SCALE = 2^FS_W - 1 through its reciprocal
  always_comb begin
    rq_sum = {1'b0, prod_r} + {1'b0, (prod_r >> ksm_pkg::FS_W)}
             + (ksm_pkg::DVD_W + 1)'(1);
    rq = rq_sum[ksm_pkg::FS_W +: DW];
    cand_full = {1'b0, rq} + {1'b0, lo_r};
    if (cand_full > {1'b0, hi_r}) begin
      cand_c = hi_r;
    end else begin
      cand_c = cand_full[DW-1:0];
    end
    held_diff = {1'b0, held_r} - {1'b0, lo_r};
    held_mag = held_diff[DW] ? DW'(-held_diff) : held_diff[DW-1:0];
  end

  always_comb begin
    centre_s = sign_r ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    diff_s = $signed(CW'(lvl_r)) - centre_s;
    dabs = diff_s[CW-1] ? CW'(-diff_s) : CW'(diff_s);
    if (degen_r) begin
      ns_c = lo_r;
    end else if (!heldv_r || (cand_r == held_r)) begin
      ns_c = cand_r;
    end else if (dabs >= CW'(hyst)) begin
      ns_c = cand_r;
    end else begin
      ns_c = held_r;
    end
    schg_c = !heldv_r || (ns_c != held_r);
  end

  assign divisor = ksm_pkg::DV_W'(span_r);

  ksm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (divisor),
    .quotient (quo),
    .busy     (div_busy),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      s_rd <= smem[idx_r];
      r_rd <= rmem[idx_r];
    end
    if (cmd.smooth) begin
      smem[idx_r] <= lvl_c;
      if (rep_c) begin
        rmem[idx_r] <= lvl_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      ch_r <= s_tdata[ksm_pkg::CH_W-1:0];
      smp_r <= s_tdata[ksm_pkg::CH_W +: DW];
      idx_r <= idx_tab[s_tdata[ksm_pkg::CH_W-1:0]];
    end
    if (cmd.smooth) begin
      lvl_r <= lvl_c;
      rep_r <= rep_c;
      hit_r <= hit_c;
      lo_r <= lo_c;
      hi_r <= hi_c;
      span_r <= hi_c - lo_c;
      held_r <= held_c;
      heldv_r <= heldv_c;
      degen_r <= degen_c;
    end
    if (cmd.mul) begin
      prod_r <= ksm_pkg::DVD_W'(lvl_r) * ksm_pkg::DVD_W'(span_r);
    end
    if (cmd.cmul) begin
      prod_r <= ksm_pkg::DVD_W'(held_mag) * ksm_pkg::DVD_W'(ksm_pkg::FULL_SCALE);
      sign_r <= held_diff[DW];
    end
    if (cmd.cand) begin
      cand_r <= cand_c;
    end
    if (cmd.fin) begin
      if (hit_r == ksm_pkg::HIT_NONE) begin
        sval_r <= '0;
        schg_r <= 1'b0;
      end else begin
        sval_r <= ns_c;
        schg_r <= schg_c;
      end
      if (hit_r == ksm_pkg::HIT_A) begin
        held_a <= ns_c;
      end
      if (hit_r == ksm_pkg::HIT_B) begin
        held_b <= ns_c;
      end
    end
    if (cmd.load_out) begin
      m_tdata <= ksm_pkg::M_TDATA_W'({schg_r, sval_r, hit_r, rep_r, lvl_r, ch_r});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_val <= '0;
      r_val <= '0;
      held_a_v <= 1'b0;
      held_b_v <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.smooth) begin
        s_val[idx_r] <= 1'b1;
        if (rep_c) begin
          r_val[idx_r] <= 1'b1;
        end
      end
      if (cmd.fin && (hit_r == ksm_pkg::HIT_A)) begin
        held_a_v <= 1'b1;
      end
      if (cmd.fin && (hit_r == ksm_pkg::HIT_B)) begin
        held_b_v <= 1'b1;
      end
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.stepped = (hit_c != ksm_pkg::HIT_NONE) && !degen_c;
    stat.need_centre = heldv_r && (cand_c != held_r);
    stat.div_busy = div_busy;
    stat.div_done = div_done;
    stat.out_free = !m_tvalid || m_tready;
  end

endmodule

// File: design/ksm_ctrl.sv
module ksm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  ksm_pkg::stat_t  stat,
  output ksm_pkg::cmd_t   cmd
);

  ksm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ksm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = (state == ksm_pkg::ST_IDLE);
    case (state)
      ksm_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          cmd.cap_in = 1'b1;
          state_next = ksm_pkg::ST_READ;
        end
      end
      ksm_pkg::ST_READ: begin
        cmd.rd = 1'b1;
        state_next = ksm_pkg::ST_SMOOTH;
      end
      ksm_pkg::ST_SMOOTH: begin
        cmd.smooth = 1'b1;
        state_next = stat.stepped ? ksm_pkg::ST_MUL : ksm_pkg::ST_FIN;
      end
      ksm_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = ksm_pkg::ST_CAND;
      end
      ksm_pkg::ST_GO: begin
        cmd.div_start = 1'b1;
        state_next = ksm_pkg::ST_WAIT;
      end
      ksm_pkg::ST_WAIT: begin
        if (stat.div_done) begin
          state_next = ksm_pkg::ST_FIN;
        end
      end
      ksm_pkg::ST_CAND: begin
        cmd.cand = 1'b1;
        state_next = stat.need_centre ? ksm_pkg::ST_CMUL : ksm_pkg::ST_FIN;
      end
      ksm_pkg::ST_CMUL: begin
        cmd.cmul = 1'b1;
        state_next = ksm_pkg::ST_GO;
      end
      ksm_pkg::ST_FIN: begin
        cmd.fin = 1'b1;
        state_next = ksm_pkg::ST_OUT;
      end
      ksm_pkg::ST_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next = ksm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ksm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/knob_smoother_with_stepped_map.sv
// Knob smoother with stepped map.
// Input stream s_*: one beat per potentiometer sample (channel, sample).
// Output stream m_*: exactly one beat per input beat, in order, carrying the
// smoothed level, report flag and, for the two stepped controls, the step.
// Configuration is a write port (cfg_we, cfg_index, cfg_data); write it
// only while no beat is in flight.
// One sample is processed at a time. A sample that does not hit a stepped
// control, or hits one whose max is not above its min, goes from smoothing
// straight to finishing and output. A stepped hit maps the level with a
// multiply and a constant reciprocal; when the candidate leaves the held
// step, the step centre runs the serial divider (one quotient bit per cycle,
// D = 20 bits wide by default) before the result is finished.
// The result sits in an output register, so a stalled receiver only holds
// the block once the next result is finished and waits for that register.
// Reset (rst, synchronous) restores register defaults and forgets all
// per-channel history and held steps; no clearing pass is needed.
module knob_smoother_with_stepped_map #(
  parameter int CHANNEL_COUNT = ksm_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // channel[3:0], sample[13:4], zero[15:14]
  input  logic [ksm_pkg::S_TDATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // channel_out[3:0], level[13:4], reported[14], stepped_hit[16:15],
  // step_value[26:17], step_changed[27], zero[31:28]
  output logic [ksm_pkg::M_TDATA_W-1:0]  m_tdata,
  input  logic                           cfg_we,
  input  logic [ksm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ksm_pkg::DATA_W-1:0]     cfg_data
);

  `include "knob_smoother_with_stepped_map_macros.svh"

  ksm_pkg::cmd_t  cmd;
  ksm_pkg::stat_t stat;

  ksm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ksm_datapath #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  `KSM_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready)
  `KSM_ASSERT_IMPL(a_no_overwrite, clk, rst, cmd.load_out, !m_tvalid || m_tready)
  `KSM_ASSERT_NEXT(a_div_runs, clk, rst, cmd.div_start, stat.div_busy)

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps

typedef struct {
  logic [ksm_pkg::CH_W-1:0]   ch;
  logic [ksm_pkg::DATA_W-1:0] level;
  logic                       reported;
  logic [1:0]                 hit;
  logic [ksm_pkg::DATA_W-1:0] step;
  logic                       step_changed;
} knob_result_t;

class knob_tracker;
  localparam int NCH = ksm_pkg::CHANNEL_COUNT_DEF;

  logic [ksm_pkg::DATA_W-1:0] threshold, hysteresis, a_min, a_max, b_min, b_max;
  logic [ksm_pkg::CH_W-1:0]   a_chan, b_chan;

  logic [ksm_pkg::DATA_W-1:0] smooth_lvl [NCH];
  bit                         smooth_ok [NCH];
  logic [ksm_pkg::DATA_W-1:0] report_lvl [NCH];
  bit                         report_ok [NCH];
  logic [ksm_pkg::DATA_W-1:0] held_a, held_b;
  bit                         held_a_ok, held_b_ok;

  knob_result_t results_due [$];
  int mismatches;

  function new();
    mismatches = 0;
    threshold  = ksm_pkg::RST_CHANGE_THRESHOLD;
    hysteresis = ksm_pkg::RST_STEP_HYSTERESIS;
    a_chan     = ksm_pkg::RST_STEP_A_CHANNEL;
    a_min      = ksm_pkg::RST_STEP_A_MIN;
    a_max      = ksm_pkg::RST_STEP_A_MAX;
    b_chan     = ksm_pkg::RST_STEP_B_CHANNEL;
    b_min      = ksm_pkg::RST_STEP_B_MIN;
    b_max      = ksm_pkg::RST_STEP_B_MAX;
    for (int i = 0; i < NCH; i++) begin
      smooth_lvl[i] = '0;
      smooth_ok[i]  = 1'b0;
      report_lvl[i] = '0;
      report_ok[i]  = 1'b0;
    end
    held_a    = '0;
    held_b    = '0;
    held_a_ok = 1'b0;
    held_b_ok = 1'b0;
  endfunction

  function void write_reg(logic [ksm_pkg::CFG_IDX_W-1:0] idx,
                          logic [ksm_pkg::DATA_W-1:0] val);
    case (idx)
      ksm_pkg::CFG_CHANGE_THRESHOLD: threshold  = val;
      ksm_pkg::CFG_STEP_HYSTERESIS:  hysteresis = val;
      ksm_pkg::CFG_STEP_A_CHANNEL:   a_chan     = val[ksm_pkg::CH_W-1:0];
      ksm_pkg::CFG_STEP_A_MIN:       a_min      = val;
      ksm_pkg::CFG_STEP_A_MAX:       a_max      = val;
      ksm_pkg::CFG_STEP_B_CHANNEL:   b_chan     = val[ksm_pkg::CH_W-1:0];
      ksm_pkg::CFG_STEP_B_MIN:       b_min      = val;
      ksm_pkg::CFG_STEP_B_MAX:       b_max      = val;
      default: ;
    endcase
  endfunction

  function logic [ksm_pkg::DATA_W-1:0] pick_step(int lvl, int held, bit held_ok,
                                                 int lo, int hi);
    longint cand, centre, dev;
    if (hi <= lo) return ksm_pkg::DATA_W'(lo);
    cand = lo + (longint'(lvl) * (hi - lo)) / ksm_pkg::FULL_SCALE;
    if (cand > hi) cand = hi;
    if (!held_ok || cand == held) return ksm_pkg::DATA_W'(cand);
    centre = (longint'(held - lo) * ksm_pkg::FULL_SCALE) / (hi - lo);
    dev = lvl - centre;
    if (dev < 0) dev = -dev;
    if (dev >= longint'(hysteresis)) return ksm_pkg::DATA_W'(cand);
    return ksm_pkg::DATA_W'(held);
  endfunction

  function void note_sample(logic [ksm_pkg::CH_W-1:0] ch, logic [ksm_pkg::DATA_W-1:0] smp);
    int idx, lvl, dlt;
    knob_result_t r;
    logic [ksm_pkg::DATA_W-1:0] ns;
    r = '{default: '0};
    idx = ch % NCH;
    if (!smooth_ok[idx])
      lvl = smp;
    else
      lvl = (int'(smooth_lvl[idx]) * ((1 << ksm_pkg::SMOOTH_SHIFT) - 1) + int'(smp))
            >> ksm_pkg::SMOOTH_SHIFT;
    r.ch = ch;
    r.level = ksm_pkg::DATA_W'(lvl);
    smooth_lvl[idx] = r.level;
    smooth_ok[idx]  = 1'b1;
    dlt = report_ok[idx] ? int'(r.level) - int'(report_lvl[idx]) : 0;
    if (dlt < 0) dlt = -dlt;
    if (!report_ok[idx] || dlt >= int'(threshold)) begin
      r.reported = 1'b1;
      report_lvl[idx] = r.level;
      report_ok[idx]  = 1'b1;
      if (ch == a_chan) begin
        ns = pick_step(r.level, held_a, held_a_ok, a_min, a_max);
        r.hit = ksm_pkg::HIT_A;
        r.step_changed = !held_a_ok || ns != held_a;
        held_a = ns;
        held_a_ok = 1'b1;
        r.step = ns;
      end else if (ch == b_chan) begin
        ns = pick_step(r.level, held_b, held_b_ok, b_min, b_max);
        r.hit = ksm_pkg::HIT_B;
        r.step_changed = !held_b_ok || ns != held_b;
        held_b = ns;
        held_b_ok = 1'b1;
        r.step = ns;
      end
    end
    results_due.push_back(r);
  endfunction

  function void compare_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  function void check_beat(logic [ksm_pkg::M_TDATA_W-1:0] d);
    knob_result_t e;
    if (results_due.size() == 0) begin
      $error("result beat %h with nothing expected", d);
      mismatches++;
      return;
    end
    e = results_due.pop_front();
    compare_field("channel_out", e.ch, d[3:0]);
    compare_field("level", e.level, d[13:4]);
    compare_field("reported", e.reported, d[14]);
    compare_field("stepped_hit", e.hit, d[16:15]);
    compare_field("step_value", e.step, d[26:17]);
    compare_field("step_changed", e.step_changed, d[27]);
  endfunction
endclass

module tb;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [ksm_pkg::S_TDATA_W-1:0] s_tdata;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [ksm_pkg::M_TDATA_W-1:0] m_tdata;
  logic                          cfg_we;
  logic [ksm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ksm_pkg::DATA_W-1:0]    cfg_data;

  knob_tracker tracker = new();
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int knob_pos [ksm_pkg::CHANNEL_COUNT_DEF];

  knob_smoother_with_stepped_map #(
    .CHANNEL_COUNT(ksm_pkg::CHANNEL_COUNT_DEF)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : result_sink
    int stall;
    m_tready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 18) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid === 1'b1 && m_tready === 1'b1));
      tracker.check_beat(m_tdata);
    end
  end

  function automatic int clamp_level(int v);
    if (v < 0) return 0;
    if (v > ksm_pkg::FULL_SCALE) return ksm_pkg::FULL_SCALE;
    return v;
  endfunction

  task automatic send_sample(input int ch, input int smp);
    int gap;
    gap = tx_idle ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, ksm_pkg::DATA_W'(smp), ksm_pkg::CH_W'(ch)};
    do @(posedge clk); while (s_tready !== 1'b1);
    tracker.note_sample(ksm_pkg::CH_W'(ch), ksm_pkg::DATA_W'(smp));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (tracker.results_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic put_reg(input logic [ksm_pkg::CFG_IDX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= ksm_pkg::DATA_W'(val);
    @(posedge clk);
    tracker.write_reg(idx, ksm_pkg::DATA_W'(val));
  endtask

  task automatic load_regs(input int thr, input int hyst, input int a_ch, input int a_lo,
                           input int a_hi, input int b_ch, input int b_lo, input int b_hi);
    put_reg(ksm_pkg::CFG_CHANGE_THRESHOLD, thr);
    put_reg(ksm_pkg::CFG_STEP_HYSTERESIS, hyst);
    put_reg(ksm_pkg::CFG_STEP_A_CHANNEL, a_ch);
    put_reg(ksm_pkg::CFG_STEP_A_MIN, a_lo);
    put_reg(ksm_pkg::CFG_STEP_A_MAX, a_hi);
    put_reg(ksm_pkg::CFG_STEP_B_CHANNEL, b_ch);
    put_reg(ksm_pkg::CFG_STEP_B_MIN, b_lo);
    put_reg(ksm_pkg::CFG_STEP_B_MAX, b_hi);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int r, ch, a_lo, a_hi, b_lo, b_hi, a_ch, b_ch;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    for (int i = 0; i < ksm_pkg::CHANNEL_COUNT_DEF; i++)
      knob_pos[i] = $urandom_range(0, ksm_pkg::FULL_SCALE);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // defaults: first loads, smoothing, both stepped controls
    send_sample(0, 0);
    send_sample(0, 1023);
    send_sample(15, 1023);
    send_sample(15, 0);
    send_sample(ksm_pkg::RST_STEP_A_CHANNEL, 0);
    send_sample(ksm_pkg::RST_STEP_A_CHANNEL, 1023);
    send_sample(ksm_pkg::RST_STEP_A_CHANNEL, 1023);
    send_sample(ksm_pkg::RST_STEP_A_CHANNEL, 512);
    send_sample(ksm_pkg::RST_STEP_A_CHANNEL, 500);
    send_sample(ksm_pkg::RST_STEP_B_CHANNEL, 1023);
    send_sample(ksm_pkg::RST_STEP_B_CHANNEL, 0);

    // zero threshold and hysteresis, shared stepped channel, inverted range on B
    wait_idle();
    load_regs(0, 0, 5, 0, 1023, 5, 1023, 0);
    send_sample(5, 0);
    send_sample(5, 1023);
    send_sample(5, 1023);
    send_sample(5, 300);

    // full-scale threshold and hysteresis, flat range on A
    wait_idle();
    load_regs(1023, 1023, 3, 100, 100, 12, 0, 1023);
    send_sample(3, 700);
    send_sample(3, 0);
    send_sample(12, 1023);
    send_sample(12, 0);
    send_sample(12, 0);

    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      case (phase)
        0: load_regs(ksm_pkg::RST_CHANGE_THRESHOLD, ksm_pkg::RST_STEP_HYSTERESIS,
                     ksm_pkg::RST_STEP_A_CHANNEL, ksm_pkg::RST_STEP_A_MIN,
                     ksm_pkg::RST_STEP_A_MAX, ksm_pkg::RST_STEP_B_CHANNEL,
                     ksm_pkg::RST_STEP_B_MIN, ksm_pkg::RST_STEP_B_MAX);
        1: load_regs(0, 0, 15, 0, 1023, 0, 1023, 0);
        2: load_regs(1023, 1023, 7, 0, 1023, 7, 5, 900);
        default: begin
          r = $urandom_range(0, 9);
          a_ch = $urandom_range(0, 15);
          b_ch = ($urandom_range(0, 5) == 0) ? a_ch : $urandom_range(0, 15);
          a_lo = $urandom_range(0, 1023);
          a_hi = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1023)
                                               : $urandom_range(a_lo, 1023);
          b_lo = $urandom_range(0, 1023);
          b_hi = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1023)
                                               : $urandom_range(b_lo, 1023);
          load_regs(r < 2 ? 0 : r < 8 ? $urandom_range(1, 12) : $urandom_range(13, 1023),
                    ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, 60),
                    a_ch, a_lo, a_hi, b_ch, b_lo, b_hi);
        end
      endcase
      tx_idle = (phase == 0) || ($urandom_range(0, 3) != 0);
      rx_idle = (phase == 1) || ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 250; n++) begin
        r = $urandom_range(0, 9);
        ch = r < 4 ? tracker.a_chan : r < 7 ? tracker.b_chan : $urandom_range(0, 15);
        r = $urandom_range(0, 9);
        if (r < 5)
          knob_pos[ch] = clamp_level(knob_pos[ch] + $urandom_range(0, 40) - 20);
        else if (r < 7)
          knob_pos[ch] = $urandom_range(0, ksm_pkg::FULL_SCALE);
        else if (r < 8)
          knob_pos[ch] = $urandom_range(0, 1) ? ksm_pkg::FULL_SCALE : 0;
        send_sample(ch, clamp_level(knob_pos[ch] + $urandom_range(0, 4) - 2));
      end
    end

    wait_idle();
    if (tracker.mismatches == 0 && tracker.results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// File: knob_smoother_with_stepped_map.f
+incdir+design
design/ksm_pkg.sv
design/ksm_div.sv
design/ksm_datapath.sv
design/ksm_ctrl.sv
design/knob_smoother_with_stepped_map.sv
test/tb.sv
